// File: hdl/iorc_pkg.sv
// ----------------------------------------------------------------------------
// iorc_pkg
// types and constants shared by the interrupt redirection controller
// ----------------------------------------------------------------------------
package iorc_pkg;

   localparam logic [2:0] OP_READ    = 3'd0;
   localparam logic [2:0] OP_WRITE   = 3'd1;
   localparam logic [2:0] OP_HIGH    = 3'd2;
   localparam logic [2:0] OP_LOW     = 3'd3;
   localparam logic [2:0] OP_RISE    = 3'd4;
   localparam logic [2:0] OP_FALL    = 3'd5;
   localparam logic [2:0] OP_EOI     = 3'd6;

   localparam logic [63:0] RTE_RESET = 64'h0001000000010000;
   localparam logic [31:0] RO_BITS   = 32'h00004000 | 32'h00001000;
   localparam logic [7:0]  VERSION_CODE = 8'h11;
   localparam logic [31:0] UNMAPPED  = 32'hFFFFFFFF;
   localparam logic [7:0]  BYTE_MASK = 8'hFF;

   localparam int BIT_DESTLOG = 11;
   localparam int BIT_POL     = 13;
   localparam int BIT_RIRR    = 14;
   localparam int BIT_TRIG    = 15;
   localparam int BIT_MASK    = 16;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  access_size;
      logic [11:0] offset;
      logic [31:0] write_data;
      logic [5:0]  pin;
      logic [7:0]  eoi_vector;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] read_data;
      logic        status;
      logic [7:0]  int_vector;
      logic [7:0]  int_dest;
      logic        int_dest_physical;
      logic [2:0]  int_delivery_mode;
      logic        int_level;
      logic        last;
   } rsp_type;

   // classified item from front to back
   typedef struct packed {
      logic        bad_size;
      req_type     req;
   } cmd_type;

endpackage

// File: hdl/iorc_front.sv
// ----------------------------------------------------------------------------
// iorc_front
// accepts items, classifies the access size and queues them for the back end
// ----------------------------------------------------------------------------
module iorc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  iorc_pkg::req_type req_item,
   output logic              q_valid,
   output iorc_pkg::cmd_type q_cmd,
   input  logic              q_pop
);
   import iorc_pkg::*;

   // two entry queue
   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    cmd;

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd = mem_ff[rp_ff];

   always_comb begin
      cmd.req = req_item;
      cmd.bad_size = (req_item.op == OP_READ || req_item.op == OP_WRITE) &&
                     (req_item.access_size != 4'd4);
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= cmd;
      end
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hdl/iorc_back.sv
// ----------------------------------------------------------------------------
// iorc_back
// executes queued items against the register file and redirection table
// ----------------------------------------------------------------------------
module iorc_back #(
   parameter int NPINS = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  iorc_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   output iorc_pkg::rsp_type rsp_item
);
   import iorc_pkg::*;

   localparam int PW = 6;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_PULSE = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   cmd_type          cmd_ff;
   logic [PW-1:0]    idx_ff, idx_in;
   logic [31:0]      rd_ff, rd_in;
   logic [NPINS-1:0] lvl_ff, lvl_in;
   logic [NPINS-1:0] rirr_ff, rirr_in;
   logic [NPINS-1:0] vld_ff, vld_in;
   logic [63:0]      rte_ff [NPINS];
   logic [63:0]      rte_rd_ff;
   logic [PW-1:0]    rte_addr;
   logic [7:0]       sel_ff, sel_in;
   logic [3:0]       id_ff, id_in;

   logic             wr_en;
   logic [PW-1:0]    wr_idx;
   logic [63:0]      wr_val;
   logic             o_valid_in;
   rsp_type          o_in;
   rsp_type          o_ff;
   logic             o_valid_ff;

   logic [PW-1:0]    p;
   logic [63:0]      e, ne;
   logic             in_tab, win;
   logic [7:0]       roff;
   logic             lv;

   function automatic rsp_type deliv(input logic [63:0] r);
      rsp_type o;
      o = '0;
      o.kind = 1'b1;
      o.int_vector = r[7:0];
      o.int_dest = r[63:56];
      o.int_dest_physical = ~r[BIT_DESTLOG];
      o.int_delivery_mode = r[10:8];
      o.int_level = r[BIT_TRIG];
      return o;
   endfunction

   assign rsp_valid = o_valid_ff;
   assign rsp_item = o_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      rd_in = rd_ff;
      lvl_in = lvl_ff;
      rirr_in = rirr_ff;
      vld_in = vld_ff;
      sel_in = sel_ff;
      id_in = id_ff;
      wr_en = 1'b0;
      wr_idx = idx_ff;
      wr_val = '0;
      o_valid_in = 1'b0;
      o_in = '0;
      q_pop = 1'b0;
      p = cmd_ff.req.pin;
      rte_addr = cmd_ff.req.pin;
      e = '0;
      ne = '0;
      lv = 1'b0;
      roff = sel_ff - 8'h10;
      win = cmd_ff.req.offset == 12'd16;
      in_tab = sel_ff >= 8'h10 && {1'b0, roff} < 9'(2 * NPINS);
      case (state_ff)
         S_IDLE: begin
            // fetch the entry the next item works on
            if (q_cmd.req.op == OP_READ || q_cmd.req.op == OP_WRITE) begin
               rte_addr = roff[PW:1];
            end else begin
               rte_addr = q_cmd.req.pin;
            end
            if (q_valid) begin
               q_pop = 1'b1;
               state_in = S_EXEC;
               rd_in = '0;
               idx_in = '0;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (cmd_ff.req.op)
               OP_READ: begin
                  if (!cmd_ff.bad_size) begin
                     if (cmd_ff.req.offset == 12'd0) begin
                        rd_in = {24'd0, sel_ff};
                     end else if (win) begin
                        if (sel_ff == 8'd0 || sel_ff == 8'd2) begin
                           rd_in = {4'd0, id_ff, 24'd0};
                        end else if (sel_ff == 8'd1) begin
                           rd_in = {8'd0, 8'(NPINS - 1), 8'd0, VERSION_CODE};
                        end else if (in_tab) begin
                           e = vld_ff[roff[PW:1]] ? rte_rd_ff : RTE_RESET;
                           e[BIT_RIRR] = rirr_ff[roff[PW:1]];
                           rd_in = roff[0] ? e[63:32] : e[31:0];
                        end
                     end else begin
                        rd_in = UNMAPPED;
                     end
                  end
               end
               OP_WRITE: begin
                  if (!cmd_ff.bad_size) begin
                     if (cmd_ff.req.offset == 12'd0) begin
                        sel_in = cmd_ff.req.write_data[7:0] & BYTE_MASK;
                     end else if (win) begin
                        if (sel_ff == 8'd0) begin
                           id_in = cmd_ff.req.write_data[27:24];
                        end else if (in_tab) begin
                           p = roff[PW:1];
                           e = vld_ff[p] ? rte_rd_ff : RTE_RESET;
                           e[BIT_RIRR] = rirr_ff[p];
                           ne = e;
                           if (roff[0]) begin
                              ne[63:32] = cmd_ff.req.write_data;
                           end else begin
                              ne[31:0] = (e[31:0] & RO_BITS) |
                                         (cmd_ff.req.write_data & ~RO_BITS);
                           end
                           if (!ne[BIT_TRIG]) begin
                              ne[BIT_RIRR] = 1'b0;
                           end
                           lv = ne[BIT_POL] ? !lvl_ff[p] : lvl_ff[p];
                           if (!ne[BIT_MASK] && !ne[BIT_RIRR] && lv) begin
                              o_valid_in = 1'b1;
                              o_in = deliv(ne);
                              if (ne[BIT_TRIG]) begin
                                 ne[BIT_RIRR] = 1'b1;
                              end
                           end
                           wr_en = 1'b1;
                           wr_idx = p;
                           wr_val = ne;
                           vld_in[p] = 1'b1;
                           rirr_in[p] = ne[BIT_RIRR];
                        end
                     end
                  end
               end
               OP_HIGH, OP_LOW, OP_RISE, OP_FALL: begin
                  if (32'(cmd_ff.req.pin) < NPINS) begin
                     e = vld_ff[p] ? rte_rd_ff : RTE_RESET;
                     lv = (cmd_ff.req.op == OP_HIGH || cmd_ff.req.op == OP_RISE);
                     lvl_in[p] = lv;
                     if (lvl_ff[p] != lv && (lv ^ e[BIT_POL]) && !e[BIT_MASK] &&
                         !(e[BIT_TRIG] && rirr_ff[p])) begin
                        o_valid_in = 1'b1;
                        o_in = deliv(e);
                        rirr_in[p] = rirr_ff[p] | e[BIT_TRIG];
                     end
                     if (cmd_ff.req.op == OP_RISE || cmd_ff.req.op == OP_FALL) begin
                        state_in = S_PULSE;
                     end
                  end
               end
               OP_EOI: begin
                  rte_addr = '0;
                  state_in = S_SCAN;
               end
               default: begin
               end
            endcase
         end
         S_PULSE: begin
            e = vld_ff[p] ? rte_rd_ff : RTE_RESET;
            lv = ~lvl_ff[p];
            lvl_in[p] = lv;
            if ((lv ^ e[BIT_POL]) && !e[BIT_MASK] && !(e[BIT_TRIG] && rirr_ff[p])) begin
               o_valid_in = 1'b1;
               o_in = deliv(e);
               rirr_in[p] = rirr_ff[p] | e[BIT_TRIG];
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            p = idx_ff;
            rte_addr = idx_ff + 1'b1;
            e = vld_ff[p] ? rte_rd_ff : RTE_RESET;
            if (e[7:0] == cmd_ff.req.eoi_vector && rirr_ff[p]) begin
               rirr_in[p] = 1'b0;
               lv = e[BIT_POL] ? !lvl_ff[p] : lvl_ff[p];
               if (lv && !e[BIT_MASK]) begin
                  o_valid_in = 1'b1;
                  o_in = deliv(e);
                  rirr_in[p] = e[BIT_TRIG];
               end
            end
            idx_in = idx_ff + 1'b1;
            if (32'(idx_ff) == NPINS - 1) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            o_valid_in = 1'b1;
            o_in = '0;
            o_in.read_data = rd_ff;
            o_in.status = cmd_ff.bad_size;
            o_in.last = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
      if (wr_en) begin
         rte_ff[wr_idx] <= wr_val;
      end
      rte_rd_ff <= rte_ff[rte_addr];
      rd_ff <= rd_in;
      idx_ff <= idx_in;
      o_ff <= o_in;
      if (reset) begin
         state_ff <= S_IDLE;
         lvl_ff <= '0;
         rirr_ff <= '0;
         vld_ff <= '0;
         sel_ff <= '0;
         id_ff <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lvl_ff <= lvl_in;
         rirr_ff <= rirr_in;
         vld_ff <= vld_in;
         sel_ff <= sel_in;
         id_ff <= id_in;
         o_valid_ff <= o_valid_in;
      end
   end

endmodule

// File: hdl/io_interrupt_redirection_controller.sv
// a bus or level item passes the queue and the idle, exec and done states before its completion strobe;
// a pulse adds the pulse state and an eoi the scan state, which walks the table one entry a cycle
// throughput: one item in flight in the back end; a two item queue takes more
// reset: synchronous, clears every entry to masked, levels, index and id
// the receiver cannot stall; each result shows for one cycle on rsp_valid
// ----------------------------------------------------------------------------
// io_interrupt_redirection_controller
// indirectly addressed interrupt redirection controller, top level
// ----------------------------------------------------------------------------
module io_interrupt_redirection_controller #(
   parameter int NPINS = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  iorc_pkg::req_type req_item,
   output logic              rsp_valid,
   output iorc_pkg::rsp_type rsp_item
);
   import iorc_pkg::*;

   logic    q_valid, q_pop;
   cmd_type q_cmd;

   iorc_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
   );

   iorc_back #(.NPINS(NPINS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_cmd(q_cmd),
      .q_pop(q_pop), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

endmodule

// File: hdl/iorc_checker.sv
// ----------------------------------------------------------------------------
// iorc_checker
// port level checks on the redirection controller
// ----------------------------------------------------------------------------
module iorc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input iorc_pkg::rsp_type rsp_item
);
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result after reset");
   a_last_is_completion: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last |-> !rsp_item.kind) else $error("bad last");
   a_delivery_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind |-> rsp_item.read_data == 32'd0 && !rsp_item.status)
      else $error("dirty delivery");
   a_kind_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.kind |-> rsp_item.last) else $error("completion w/o last");
   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy)) else $error("busy without item");
endmodule

bind io_interrupt_redirection_controller iorc_checker u_iorc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_item(rsp_item)
);
